// ===== rtl/core/ccp_pkg.sv =====
// Shared constants and types of the circle collision pair core.
`default_nettype none

package ccp_pkg;

	// Default sizes
	localparam int BODIES_DEF     = 16;
	localparam int COORD_BITS_DEF = 24;

	// Fixed field widths
	localparam int CMD_W      = 2;
	localparam int SLOT_W     = 4;
	localparam int POS_W      = 24;
	localparam int RADIUS_W   = 16;
	localparam int MASK_W     = 16;
	localparam int SLOT_LIMIT = 16;

	// Command codes of an input item
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_TICK   = 2'd2
	} cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_ISSUE,
		ST_WAIT,
		ST_EMIT
	} state_t;

	// Tag that travels with one pair test
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              last;
	} pair_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/ccp_body_mem.sv =====
// Body table memory: one write port, two registered read ports.
`default_nettype none

module ccp_body_mem #(
	parameter int DEPTH  = ccp_pkg::BODIES_DEF,
	parameter int DATA_W = 2 * ccp_pkg::COORD_BITS_DEF + ccp_pkg::RADIUS_W,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [DATA_W-1:0] rdata_a,
	output logic      [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// ===== rtl/core/ccp_pair_test.sv =====
// Pipelined overlap test of two circles: distance, squares, compare.
`default_nettype none

module ccp_pair_test #(
	parameter int COORD_BITS = ccp_pkg::COORD_BITS_DEF,
	localparam int ENTRY_W = 2 * COORD_BITS + ccp_pkg::RADIUS_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire ccp_pkg::pair_tag_t  in_tag,
	input  wire logic [ENTRY_W-1:0]  a_entry,
	input  wire logic [ENTRY_W-1:0]  b_entry,
	output logic                     hit_vld,
	output ccp_pkg::pair_tag_t       hit_tag,
	output logic                     hit
);

	localparam int C    = COORD_BITS;
	localparam int R    = ccp_pkg::RADIUS_W;
	localparam int RS_W = R + 1;
	localparam int SQ_W = 2 * RS_W;

	logic [C-1:0] ax, ay, bx, by;
	logic [R-1:0] ar, br;
	logic [C:0]   dxd, dyd, dxn, dyn;
	logic [C-1:0] dxa, dya;
	logic [RS_W-1:0] rs;
	logic            far;

	logic [C-1:0]    dx_s2, dy_s2;
	logic [RS_W-1:0] rs_s2;
	logic            far_s2, vld_s2;
	ccp_pkg::pair_tag_t tag_s2;

	logic [31:0]     dxw, dyw, rsw;
	logic [SQ_W-1:0] sqx_s3, sqy_s3, rs2_s3;
	logic            far_s3, vld_s3;
	ccp_pkg::pair_tag_t tag_s3;

	logic [SQ_W:0]   dist2;
	logic            hit_s4, vld_s4;
	ccp_pkg::pair_tag_t tag_s4;

	// unpack {x, y, r}
	assign ax = a_entry[ENTRY_W-1 -: C];
	assign ay = a_entry[R +: C];
	assign ar = a_entry[R-1:0];
	assign bx = b_entry[ENTRY_W-1 -: C];
	assign by = b_entry[R +: C];
	assign br = b_entry[R-1:0];

	// axis distances and radius sum
	always_comb begin
		dxd = {ax[C-1], ax} - {bx[C-1], bx};
		dyd = {ay[C-1], ay} - {by[C-1], by};
		dxn = -dxd;
		dyn = -dyd;
		dxa = dxd[C] ? dxn[C-1:0] : dxd[C-1:0];
		dya = dyd[C] ? dyn[C-1:0] : dyd[C-1:0];
		rs  = {1'b0, ar} + {1'b0, br};
		far = (32'(dxa) > 32'(rs)) || (32'(dya) > 32'(rs));
	end

	// a near pair has both distances within 17 bits
	assign dxw = 32'(dx_s2);
	assign dyw = 32'(dy_s2);
	assign rsw = 32'(rs_s2);

	assign dist2 = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		dx_s2  <= dxa;
		dy_s2  <= dya;
		rs_s2  <= rs;
		far_s2 <= far;
		tag_s2 <= in_tag;

		sqx_s3 <= dxw[RS_W-1:0] * dxw[RS_W-1:0];
		sqy_s3 <= dyw[RS_W-1:0] * dyw[RS_W-1:0];
		rs2_s3 <= rsw[RS_W-1:0] * rsw[RS_W-1:0];
		far_s3 <= far_s2;
		tag_s3 <= tag_s2;

		hit_s4 <= !far_s3 && (dist2 <= {1'b0, rs2_s3});
		tag_s4 <= tag_s3;
	end

	assign hit_vld = vld_s4;
	assign hit_tag = tag_s4;
	assign hit     = hit_s4;

endmodule

`default_nettype wire

// ===== rtl/core/circle_collision_pairs_core.sv =====
// Load/remove: taken while idle. Tick: the sequencer steps over each empty slot ahead of the last valid body
// (every slot when none is valid), and per valid body issues one pair test per slot
// (min(BODIES,16)), all through one pair test pipeline fed by the body table's
// two read ports; the sequencer holds while a result waits for res_ready.
// The next item is taken once the last result sits in the output register.
// Reset clears the valid and pending-removal bits; table contents are undefined.
`default_nettype none

module circle_collision_pairs_core #(
	parameter int BODIES     = ccp_pkg::BODIES_DEF,
	parameter int COORD_BITS = ccp_pkg::COORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_ready,
	input  wire logic [ccp_pkg::CMD_W-1:0]      command,
	input  wire logic [ccp_pkg::SLOT_W-1:0]     slot,
	input  wire logic signed [ccp_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [ccp_pkg::POS_W-1:0] pos_y,
	input  wire logic [ccp_pkg::RADIUS_W-1:0]   body_radius,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output logic [ccp_pkg::SLOT_W-1:0]          body_index,
	output logic                                colliding,
	output logic [ccp_pkg::MASK_W-1:0]          partner_mask,
	output logic                                last
);

	localparam int LIM     = (BODIES < ccp_pkg::SLOT_LIMIT) ? BODIES : ccp_pkg::SLOT_LIMIT;
	localparam int LIM_W   = $clog2(LIM);
	localparam int IDX_W   = $clog2(BODIES);
	localparam int ENTRY_W = 2 * COORD_BITS + ccp_pkg::RADIUS_W;

	ccp_pkg::state_t state_q, state_d;

	logic [LIM_W-1:0]  e_q, f_q;
	logic [BODIES-1:0] valid_q, pending_q;
	logic [LIM-1:0]    mask_q, self_bit, pmask;

	logic accept, slot_ok, is_load, is_remove, is_tick;
	logic [IDX_W-1:0] slot_idx;
	logic [31:0] px_ext, py_ext;
	logic [ENTRY_W-1:0] wdata, rdata_a, rdata_b;
	logic mem_we;

	logic e_valid, e_end, f_end, later_valid, out_free;
	logic issue, emit, finish, mask_clr, e_inc, f_clr;

	logic v_s1;
	ccp_pkg::pair_tag_t tag_s1, hit_tag;
	logic hit_vld, hit;

	// input decode
	assign accept   = cmd_valid && cmd_ready;
	assign slot_ok  = int'(slot) < BODIES;
	assign slot_idx = IDX_W'(slot);

	always_comb begin
		is_load   = 1'b0;
		is_remove = 1'b0;
		is_tick   = 1'b0;
		unique case (command)
			ccp_pkg::CMD_LOAD:   is_load = 1'b1;
			ccp_pkg::CMD_REMOVE: is_remove = 1'b1;
			ccp_pkg::CMD_TICK:   is_tick = 1'b1;
			default: ;
		endcase
	end

	// table entry {x, y, r}; coordinates keep their low COORD_BITS bits
	assign px_ext = {8'd0, pos_x};
	assign py_ext = {8'd0, pos_y};
	assign wdata  = {px_ext[COORD_BITS-1:0], py_ext[COORD_BITS-1:0], body_radius};
	assign mem_we = accept && is_load && slot_ok;

	ccp_body_mem #(
		.DEPTH  (BODIES),
		.DATA_W (ENTRY_W)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (slot_idx),
		.wdata   (wdata),
		.raddr_a (IDX_W'(e_q)),
		.raddr_b (IDX_W'(f_q)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	ccp_pair_test #(
		.COORD_BITS (COORD_BITS)
	) u_pair (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s1),
		.in_tag  (tag_s1),
		.a_entry (rdata_a),
		.b_entry (rdata_b),
		.hit_vld (hit_vld),
		.hit_tag (hit_tag),
		.hit     (hit)
	);

	// status for the sequencer
	always_comb begin
		e_valid     = valid_q[IDX_W'(e_q)];
		e_end       = (e_q == LIM_W'(LIM - 1));
		f_end       = (f_q == LIM_W'(LIM - 1));
		later_valid = 1'b0;
		for (int j = 0; j < LIM; j++) begin
			if (j > int'(e_q) && valid_q[j]) begin
				later_valid = 1'b1;
			end
		end
		out_free = !res_valid || res_ready;
		self_bit = LIM'(1) << e_q;
		pmask    = mask_q & valid_q[LIM-1:0] & ~self_bit;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		issue     = 1'b0;
		emit      = 1'b0;
		finish    = 1'b0;
		mask_clr  = 1'b0;
		e_inc     = 1'b0;
		f_clr     = 1'b0;
		unique case (state_q)
			ccp_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && is_tick) begin
					state_d = ccp_pkg::ST_NEXT;
				end
			end
			ccp_pkg::ST_NEXT: begin
				if (e_valid) begin
					mask_clr = 1'b1;
					f_clr    = 1'b1;
					state_d  = ccp_pkg::ST_ISSUE;
				end else if (e_end) begin
					finish  = 1'b1;
					state_d = ccp_pkg::ST_IDLE;
				end else begin
					e_inc = 1'b1;
				end
			end
			ccp_pkg::ST_ISSUE: begin
				issue = 1'b1;
				if (f_end) begin
					state_d = ccp_pkg::ST_WAIT;
				end
			end
			ccp_pkg::ST_WAIT: begin
				if (hit_vld && hit_tag.last) begin
					state_d = ccp_pkg::ST_EMIT;
				end
			end
			ccp_pkg::ST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (later_valid) begin
						e_inc   = 1'b1;
						state_d = ccp_pkg::ST_NEXT;
					end else begin
						finish  = 1'b1;
						state_d = ccp_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = ccp_pkg::ST_IDLE;
		endcase
	end

	// counters, body flags, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q       <= '0;
			f_q       <= '0;
			valid_q   <= '0;
			pending_q <= '0;
			v_s1      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (accept && is_tick) begin
				e_q <= '0;
			end else if (e_inc) begin
				e_q <= e_q + LIM_W'(1);
			end

			if (f_clr) begin
				f_q <= '0;
			end else if (issue) begin
				f_q <= f_q + LIM_W'(1);
			end

			if (accept && is_load && slot_ok) begin
				valid_q[slot_idx]   <= 1'b1;
				pending_q[slot_idx] <= 1'b0;
			end else if (accept && is_remove && slot_ok) begin
				pending_q[slot_idx] <= 1'b1;
			end else if (finish) begin
				valid_q   <= valid_q & ~pending_q;
				pending_q <= '0;
			end

			v_s1 <= issue;

			if (emit) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// partner mask, pair tags, result payload
	always_ff @(posedge clk) begin
		if (mask_clr) begin
			mask_q <= '0;
		end else if (hit_vld && hit) begin
			mask_q[hit_tag.slot[LIM_W-1:0]] <= 1'b1;
		end

		tag_s1.slot <= ccp_pkg::SLOT_W'(f_q);
		tag_s1.last <= f_end;

		if (emit) begin
			body_index   <= ccp_pkg::SLOT_W'(e_q);
			colliding    <= |pmask;
			partner_mask <= ccp_pkg::MASK_W'(pmask);
			last         <= !later_valid;
		end
	end

endmodule

`default_nettype wire

// ===== tb/ccp_pair_checker.sv =====
// Channel monitor, body table predictor and result comparison for the collision pair core.
`default_nettype none

module ccp_pair_checker import ccp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	input  wire logic                 cmd_ready,
	input  wire logic [CMD_W-1:0]     command,
	input  wire logic [SLOT_W-1:0]    slot,
	input  wire logic [POS_W-1:0]     pos_x,
	input  wire logic [POS_W-1:0]     pos_y,
	input  wire logic [RADIUS_W-1:0]  body_radius,
	input  wire logic                 res_valid,
	input  wire logic                 res_ready,
	input  wire logic [SLOT_W-1:0]    body_index,
	input  wire logic                 colliding,
	input  wire logic [MASK_W-1:0]    partner_mask,
	input  wire logic                 last,
	output int                        errors,
	output int                        due_count,
	output int                        loads_seen,
	output int                        removes_seen,
	output int                        ticks_seen,
	output int                        results_seen,
	output int                        hits_seen
);

	localparam int NB = BODIES_DEF;

	typedef struct {
		logic [SLOT_W-1:0] index;
		logic              hit;
		logic [MASK_W-1:0] mask;
		logic              fin;
	} body_result_t;

	// Predicted body table
	logic signed [POS_W-1:0] tab_x [NB];
	logic signed [POS_W-1:0] tab_y [NB];
	logic [RADIUS_W-1:0]     tab_r [NB];
	logic [NB-1:0]           live;
	logic [NB-1:0]           doomed;

	body_result_t results_due[$];

	// Exact circle overlap test, squared distance against squared radius sum
	function automatic bit bodies_touch(int a, int b);
		longint ax, bx, ay, by, dx, dy, rs;
		ax = tab_x[a];
		bx = tab_x[b];
		ay = tab_y[a];
		by = tab_y[b];
		dx = ax - bx;
		dy = ay - by;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		rs = longint'(tab_r[a]) + longint'(tab_r[b]);
		if (dx > rs || dy > rs)
			return 1'b0;
		return (dx * dx + dy * dy) <= rs * rs;
	endfunction

	// One pass over all valid bodies, then apply pending removals
	task automatic predict_tick();
		body_result_t r;
		logic [MASK_W-1:0] m;
		int n, k, e, f;
		n = $countones(live);
		k = 0;
		for (e = 0; e < NB; e++) begin
			if (live[e]) begin
				m = '0;
				for (f = 0; f < NB; f++)
					if (f != e && live[f] && bodies_touch(e, f))
						m[f] = 1'b1;
				k++;
				r.index = SLOT_W'(e);
				r.hit   = |m;
				r.mask  = m;
				r.fin   = (k == n);
				results_due.push_back(r);
			end
		end
		live   = live & ~doomed;
		doomed = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		body_result_t want;
		if (!arst_n) begin
			live   = '0;
			doomed = '0;
			results_due.delete();
			errors       = 0;
			due_count    = 0;
			loads_seen   = 0;
			removes_seen = 0;
			ticks_seen   = 0;
			results_seen = 0;
			hits_seen    = 0;
		end else begin
			// accepted command item
			if (cmd_valid && cmd_ready) begin
				case (cmd_t'(command))
					CMD_LOAD: begin
						tab_x[slot]  = pos_x;
						tab_y[slot]  = pos_y;
						tab_r[slot]  = body_radius;
						live[slot]   = 1'b1;
						doomed[slot] = 1'b0;
						loads_seen++;
					end
					CMD_REMOVE: begin
						doomed[slot] = 1'b1;
						removes_seen++;
					end
					CMD_TICK: begin
						predict_tick();
						ticks_seen++;
					end
					default: ;
				endcase
			end

			// accepted result item, checked against the oldest prediction
			if (res_valid && res_ready) begin
				results_seen++;
				if (colliding) hits_seen++;
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, body_index %0d partner_mask %h",
						$time, body_index, partner_mask);
				end else begin
					want = results_due.pop_front();
					if (body_index !== want.index) begin
						errors++;
						$display("%0t: body_index expected %0d got %0d",
							$time, want.index, body_index);
					end
					if (colliding !== want.hit) begin
						errors++;
						$display("%0t: colliding of body %0d expected %b got %b",
							$time, want.index, want.hit, colliding);
					end
					if (partner_mask !== want.mask) begin
						errors++;
						$display("%0t: partner_mask of body %0d expected %h got %h",
							$time, want.index, want.mask, partner_mask);
					end
					if (last !== want.fin) begin
						errors++;
						$display("%0t: last of body %0d expected %b got %b",
							$time, want.index, want.fin, last);
					end
				end
			end
			due_count = results_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Top of the collision pair testbench: clock, reset, command stimulus and verdict.
`default_nettype none

module tb;
	import ccp_pkg::*;

	localparam int LIMIT        = 1_000_000;
	localparam int DRAIN        = 400;
	localparam int PARK_CYCLES  = 2000;
	localparam int RANDOM_ITEMS = 380;
	localparam int PARK_AT      = 120;
	localparam int PAUSE_AT     = 250;

	// command code the block must ignore
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_ready;
	logic [CMD_W-1:0]    command;
	logic [SLOT_W-1:0]   slot;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [RADIUS_W-1:0] body_radius;
	logic                res_valid;
	logic                res_ready;
	logic [SLOT_W-1:0]   body_index;
	logic                colliding;
	logic [MASK_W-1:0]   partner_mask;
	logic                last;

	int errors, due_count, loads_seen, removes_seen, ticks_seen, results_seen, hits_seen;
	int cycles = 0;
	int burst_left = 0;
	logic park_req = 1'b0;
	logic park_done = 1'b0;

	circle_collision_pairs_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.command      (command),
		.slot         (slot),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.body_radius  (body_radius),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.body_index   (body_index),
		.colliding    (colliding),
		.partner_mask (partner_mask),
		.last         (last)
	);

	ccp_pair_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.command      (command),
		.slot         (slot),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.body_radius  (body_radius),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.body_index   (body_index),
		.colliding    (colliding),
		.partner_mask (partner_mask),
		.last         (last),
		.errors       (errors),
		.due_count    (due_count),
		.loads_seen   (loads_seen),
		.removes_seen (removes_seen),
		.ticks_seen   (ticks_seen),
		.results_seen (results_seen),
		.hits_seen    (hits_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, due_count);
			$display("FAIL");
			$finish;
		end
	end

	// Result side: one long hold-off on request, otherwise a rotating stall pattern
	initial begin
		int rc;
		int mode;
		rc = 0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			rc++;
			if (park_req && !park_done) begin
				res_ready <= 1'b0;
				repeat (PARK_CYCLES) @(posedge clk);
				park_done = 1'b1;
			end else begin
				mode = (rc / 64) % 4;
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= ($urandom_range(0, 99) < 70);
					2: res_ready <= ((rc >> 2) & 1) != 0;
					default: res_ready <= ($urandom_range(0, 99) < 25);
				endcase
			end
		end
	end

	// Bursts of back-to-back items separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Offer one item and hold it until the block takes it
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [RADIUS_W-1:0] r);
		cmd_valid   <= 1'b1;
		command     <= c;
		slot        <= s;
		pos_x       <= x;
		pos_y       <= y;
		body_radius <= r;
		do @(negedge clk); while (!cmd_ready);
		@(posedge clk);
		pace();
	endtask

	task automatic load_body(input logic [SLOT_W-1:0] s, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [RADIUS_W-1:0] r);
		send_item(CMD_LOAD, s, x, y, r);
	endtask

	task automatic mark_remove(input logic [SLOT_W-1:0] s);
		send_item(CMD_REMOVE, s, POS_W'($urandom), POS_W'($urandom), RADIUS_W'($urandom));
	endtask

	task automatic run_tick();
		send_item(CMD_TICK, SLOT_W'($urandom), POS_W'($urandom), POS_W'($urandom),
			RADIUS_W'($urandom));
	endtask

	// Stop offering and let every predicted result drain out
	task automatic settle();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (due_count != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	initial begin
		int n_items;
		int pick;
		int cx, cy;
		logic [POS_W-1:0] x, y;
		logic [RADIUS_W-1:0] r;

		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		command     = CMD_LOAD;
		slot        = '0;
		pos_x       = '0;
		pos_y       = '0;
		body_radius = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, ignored command, removal of an empty slot
		run_tick();
		send_item(CMD_UNUSED, 4'd7, 24'h123456, 24'h654321, 16'hA5A5);
		mark_remove(4'd5);
		run_tick();

		// coordinate and radius extremes; slot 15 overlaps slot 1
		load_body(4'd0, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
		load_body(4'd1, 24'h800000, 24'h800000, 16'hFFFF);
		load_body(4'd15, 24'h800064, 24'h800000, 16'h0000);
		// coincident zero radius bodies
		load_body(4'd2, 24'd0, 24'd0, 16'd0);
		load_body(4'd3, 24'd0, 24'd0, 16'd0);
		// touching exactly along one axis
		load_body(4'd4, 24'd1000, 24'd0, 16'd500);
		load_body(4'd5, 24'd2000, 24'd0, 16'd500);
		// 3-4-5 triangle right on the boundary
		load_body(4'd6, 24'd0, 24'd10000, 16'd2);
		load_body(4'd7, 24'd3, 24'd10004, 16'd3);
		// both axes within the radius sum, diagonal too far
		load_body(4'd8, 24'd0, 24'd20000, 16'd2);
		load_body(4'd9, 24'd3, 24'd20004, 16'd2);
		// one axis beyond the radius sum by one
		load_body(4'd10, -24'sd30000, -24'sd30000, 16'd100);
		load_body(4'd11, -24'sd29799, -24'sd30000, 16'd100);
		run_tick();

		// removal takes effect after the next tick; reload cancels a removal
		mark_remove(4'd0);
		mark_remove(4'd2);
		load_body(4'd2, 24'd0, 24'd0, 16'd0);
		run_tick();
		run_tick();

		// Random part: mostly clustered loads with removals and ticks mixed in
		cx = $urandom_range(0, 2000000) - 1000000;
		cy = $urandom_range(0, 2000000) - 1000000;
		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			if (n_items == PARK_AT) begin
				park_req <= 1'b1;
				run_tick();
				n_items++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 52) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					x = POS_W'(cx + int'($urandom_range(0, 6000)) - 3000);
					y = POS_W'(cy + int'($urandom_range(0, 6000)) - 3000);
					r = RADIUS_W'($urandom_range(0, 2500));
				end else if (pick < 90) begin
					x = POS_W'($urandom);
					y = POS_W'($urandom);
					r = RADIUS_W'($urandom);
				end else begin
					x = ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000) ^ POS_W'($urandom_range(0, 255));
					y = ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000) ^ POS_W'($urandom_range(0, 255));
					r = RADIUS_W'($urandom);
				end
				load_body(SLOT_W'($urandom), x, y, r);
				n_items++;
			end else if (pick < 66) begin
				mark_remove(SLOT_W'($urandom));
				n_items++;
			end else if (pick < 94) begin
				run_tick();
				n_items++;
			end else begin
				send_item(CMD_UNUSED, SLOT_W'($urandom), POS_W'($urandom), POS_W'($urandom),
					RADIUS_W'($urandom));
			end
			if (n_items == PAUSE_AT)
				settle();
		end

		settle();
		$display("Checked %0d loads, %0d removals and %0d ticks giving %0d body results (%0d colliding),",
			loads_seen, removes_seen, ticks_seen, results_seen, hits_seen);
		$display("with bursty input, varied output stalls, one long output hold-off and a mid-run drain.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
